/* hw/rtl/wts4_pkg.sv */
package wts4_pkg;

    // Number of implemented channels (1..4); channel select is always address bits [1:0]
    localparam int CHANNELS = 4;

    // Operation codes carried in the input tuser bit
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Register regions, address bits [4:2]
    localparam logic [2:0] RGN_KEY_LO  = 3'd0;
    localparam logic [2:0] RGN_KEY_HI  = 3'd1;
    localparam logic [2:0] RGN_XOR     = 3'd2;
    localparam logic [2:0] RGN_OFFSET  = 3'd3;
    localparam logic [2:0] RGN_NOTEOFF = 3'd4;

    // First writable wave table address
    localparam logic [7:0] TABLE_BASE = 8'h14;

    // step = key*44/101 as key * round_up(44 * 2^27 / 101) >> 27, exact for 14-bit keys
    localparam int           STEP_SHIFT = 27;
    localparam logic [25:0]  STEP_MULT  = 26'd58471090;

    // Mix bias and output offset
    localparam logic [7:0] MIX_BIAS   = 8'd3;
    localparam logic [7:0] MIX_CENTER = 8'd131;

    typedef logic [7:0] wave_rom_t [256];

    // Power-up table: noise, triangle, pulse and saw interleaved in groups of four
    function automatic wave_rom_t wave_init();
        wave_rom_t   rom;
        logic [31:0] r;
        logic [7:0]  i8;
        r = 32'h12345678;
        for (int i = 0; i < 64; i++)
        begin
            i8 = 8'(i);
            r = r + r * 32'd56465321 + 32'd456156321;
            rom[4*i]     = {2'b00, r[5:0]};
            rom[4*i + 1] = (i < 32) ? 8'(2 * i) : 8'(127 - 2 * i);
            rom[4*i + 2] = (i < 32) ? 8'd0 : 8'd63;
            rom[4*i + 3] = i8;
        end
        return rom;
    endfunction

    localparam wave_rom_t WAVE_ROM = wave_init();

endpackage

/* hw/rtl/wts4_ram.sv */
module wts4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/wavetable_synth_four_channel_unit.sv */
// Four-channel wavetable synthesizer: one write or tick per cycle while the output keeps up.
// A tick's sample passes the table read stage, then the mix and the output register;
//   writes produce no result and take effect for the next transfer.
// Throughput: one item per cycle while the output side keeps up.
// Reset (rst_n low, asynchronous): clear keys, steps, phases, XOR, offsets, active mask and
//   table valid bits; unwritten table bytes read as the power-up pattern, no clearing pass.
module wavetable_synth_four_channel_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] reg_address, [15:8] write_data
    input  logic        s_axis_tuser,   // [0] operation (0 write, 1 tick)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] sample, [11:8] active_mask, [15:12] zero
);

    localparam int NCH = wts4_pkg::CHANNELS;

    // ------------------------------------------------------------------
    // Handshake and decode of the incoming transfer
    // ------------------------------------------------------------------
    logic       in_fire;
    logic       tick_fire;
    logic       wr_fire;
    logic       out_adv;
    logic [7:0] in_addr;
    logic [7:0] in_data;
    logic [1:0] wr_ch;
    logic [2:0] wr_rgn;
    logic       wr_ch_ok;
    logic       tbl_we;
    logic       reg_we;

    // Channel state
    logic [15:0]    phase_reg  [NCH];
    logic [15:0]    phase_next [NCH];
    logic [13:0]    key_reg    [NCH];
    logic [13:0]    key_next   [NCH];
    logic [12:0]    step_reg   [NCH];
    logic [12:0]    step_next  [NCH];
    logic [7:0]     xor_reg    [NCH];
    logic [7:0]     xor_next   [NCH];
    logic [7:0]     ofs_reg    [NCH];
    logic [7:0]     ofs_next   [NCH];
    logic [NCH-1:0] active_reg;
    logic [NCH-1:0] active_next;

    // Table valid bits: set once a byte has been written, cleared by reset
    logic [255:0] tvld_reg;
    logic [255:0] tvld_next;

    // Step computation for a key-high write
    logic [13:0] sel_key;
    logic [13:0] hi_key;
    logic [39:0] step_prod;
    logic [12:0] new_step;

    // Tick lookup
    logic [7:0] rd_idx [NCH];

    // Read stage
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [NCH-1:0] s1_act_reg;
    logic [NCH-1:0] s1_vld_reg;
    logic [7:0]     s1_rom_reg [NCH];
    logic [7:0]     s1_ofs_reg [NCH];
    logic [7:0]     ram_rdata  [NCH];

    // Mix
    logic [7:0] ch_byte [NCH];
    logic [7:0] ch_sum  [NCH];
    logic [5:0] ch_val  [NCH];
    logic [7:0] mix_sum;

    // Output register
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_sample_reg;
    logic [3:0] m_mask_reg;

    assign in_addr = s_axis_tdata[7:0];
    assign in_data = s_axis_tdata[15:8];

    // Move the read stage forward when the output register is empty or being drained
    assign out_adv       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign tick_fire     = in_fire && (s_axis_tuser == wts4_pkg::OP_TICK);
    assign wr_fire       = in_fire && (s_axis_tuser == wts4_pkg::OP_WRITE);

    assign wr_ch    = in_addr[1:0];
    assign wr_rgn   = in_addr[4:2];
    assign wr_ch_ok = ({1'b0, wr_ch} < 3'(NCH));
    assign tbl_we   = wr_fire && (in_addr >= wts4_pkg::TABLE_BASE);
    assign reg_we   = wr_fire && (in_addr < wts4_pkg::TABLE_BASE) && wr_ch_ok;

    // ------------------------------------------------------------------
    // Key-high step: one constant multiply replaces key*44/101
    // ------------------------------------------------------------------
    always_comb
    begin
        sel_key = '0;
        for (int c = 0; c < NCH; c++)
        begin
            if (wr_ch == 2'(c))
            begin
                sel_key = key_reg[c];
            end
        end
    end

    assign hi_key    = {in_data[6:0], sel_key[6:0]};
    assign step_prod = 40'(hi_key) * 40'(wts4_pkg::STEP_MULT);
    assign new_step  = step_prod[wts4_pkg::STEP_SHIFT +: 13];

    // ------------------------------------------------------------------
    // Channel register updates and phase advance
    // ------------------------------------------------------------------
    always_comb
    begin
        active_next = active_reg;
        for (int c = 0; c < NCH; c++)
        begin
            phase_next[c] = phase_reg[c];
            key_next[c]   = key_reg[c];
            step_next[c]  = step_reg[c];
            xor_next[c]   = xor_reg[c];
            ofs_next[c]   = ofs_reg[c];

            // Advance only sounding channels on a tick
            if (tick_fire && active_reg[c])
            begin
                phase_next[c] = phase_reg[c] + 16'(step_reg[c]);
            end

            if (reg_we && (wr_ch == 2'(c)))
            begin
                case (wr_rgn)
                    wts4_pkg::RGN_KEY_LO:
                    begin
                        key_next[c] = {key_reg[c][13:7], in_data[6:0]};
                        if ({key_reg[c][13:7], in_data[6:0]} != 14'd0)
                        begin
                            active_next[c] = 1'b1;
                        end
                    end
                    wts4_pkg::RGN_KEY_HI:
                    begin
                        key_next[c]  = hi_key;
                        step_next[c] = new_step;
                        // A zero key leaves phase and active bit alone
                        if (hi_key != 14'd0)
                        begin
                            phase_next[c]  = '0;
                            active_next[c] = 1'b1;
                        end
                    end
                    wts4_pkg::RGN_XOR:
                    begin
                        xor_next[c] = in_data;
                    end
                    wts4_pkg::RGN_OFFSET:
                    begin
                        ofs_next[c] = in_data;
                    end
                    wts4_pkg::RGN_NOTEOFF:
                    begin
                        key_next[c]    = '0;
                        step_next[c]   = '0;
                        active_next[c] = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Table index from the advanced phase
            rd_idx[c] = {phase_next[c][14:9], 2'b00} ^ xor_reg[c];
        end
    end

    always_comb
    begin
        tvld_next = tvld_reg;
        if (tbl_we)
        begin
            tvld_next[in_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                phase_reg[c] <= '0;
                key_reg[c]   <= '0;
                step_reg[c]  <= '0;
                xor_reg[c]   <= '0;
                ofs_reg[c]   <= '0;
            end
            active_reg <= '0;
            tvld_reg   <= '0;
        end
        else
        begin
            for (int c = 0; c < NCH; c++)
            begin
                phase_reg[c] <= phase_next[c];
                key_reg[c]   <= key_next[c];
                step_reg[c]  <= step_next[c];
                xor_reg[c]   <= xor_next[c];
                ofs_reg[c]   <= ofs_next[c];
            end
            active_reg <= active_next;
            tvld_reg   <= tvld_next;
        end
    end

    // ------------------------------------------------------------------
    // Wave table: one copy per channel so every channel reads in the same cycle;
    // every table write goes to all copies
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NCH; g++)
    begin : g_tbl
        wts4_ram #(
            .WIDTH (8),
            .DEPTH (256)
        ) u_ram (
            .clk   (clk),
            .we    (tbl_we),
            .waddr (in_addr),
            .wdata (in_data),
            .re    (tick_fire),
            .raddr (rd_idx[g]),
            .rdata (ram_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // Read stage: capture what the mix needs alongside the table read
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_act_reg <= active_reg;
            for (int c = 0; c < NCH; c++)
            begin
                s1_vld_reg[c] <= tvld_reg[rd_idx[c]];
                s1_rom_reg[c] <= wts4_pkg::WAVE_ROM[rd_idx[c]];
                s1_ofs_reg[c] <= ofs_reg[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Mix: offset, saturate to 63 when bit 7 is set else keep the low 6 bits, sum with bias
    // ------------------------------------------------------------------
    always_comb
    begin
        mix_sum = wts4_pkg::MIX_BIAS;
        for (int c = 0; c < NCH; c++)
        begin
            ch_byte[c] = s1_vld_reg[c] ? ram_rdata[c] : s1_rom_reg[c];
            ch_sum[c]  = ch_byte[c] + s1_ofs_reg[c];
            ch_val[c]  = ch_sum[c][7] ? 6'd63 : ch_sum[c][5:0];
            if (s1_act_reg[c])
            begin
                mix_sum = mix_sum + 8'(ch_val[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_adv)
        begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            m_sample_reg <= mix_sum - wts4_pkg::MIX_CENTER;
            m_mask_reg   <= 4'(s1_act_reg);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_mask_reg, m_sample_reg};

endmodule

/* hw/rtl/wts4_chk.sv */
module wts4_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic tick_xfer;

    assign tick_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == wts4_pkg::OP_TICK);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A new result only follows an accepted tick that has passed the read stage
    a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(tick_xfer, 2))
        else $error("result without a tick");

    // Sample stays within -128..124 and padding is zero
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:12] == 4'd0) && (m_axis_tdata[7:0] != 8'd125)
            && (m_axis_tdata[7:0] != 8'd126) && (m_axis_tdata[7:0] != 8'd127))
        else $error("result out of range");

endmodule

bind wavetable_synth_four_channel_unit wts4_chk u_wts4_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/wavetable_synth_four_channel_unit_tb.sv */
module wavetable_synth_four_channel_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected tick result: mixed sample and active mask
    typedef struct packed {
        logic [7:0] sample;
        logic [3:0] active_mask;
    } tick_result_t;

    // Scoreboard: keeps its own copy of the synth state, predicts the result of every
    // accepted tick and compares results in order as they leave the block.
    class synth_scoreboard;
        logic [7:0]   wave_mem [256];
        logic [15:0]  phase_acc [4];
        logic [13:0]  key [4];
        logic [12:0]  step [4];
        logic [7:0]   xor_mask [4];
        logic [7:0]   offset [4];
        logic [3:0]   active;
        tick_result_t expected_q [$];
        int           errors;

        function new();
            logic [31:0] r;
            r = 32'h12345678;
            for (int i = 0; i < 64; i++)
            begin
                r = r + r * 32'd56465321 + 32'd456156321;
                wave_mem[4*i]     = {2'b00, r[5:0]};
                wave_mem[4*i + 1] = (i < 32) ? 8'(2 * i) : 8'(127 - 2 * i);
                wave_mem[4*i + 2] = (i < 32) ? 8'd0 : 8'd63;
                wave_mem[4*i + 3] = 8'(i);
            end
            for (int c = 0; c < 4; c++)
            begin
                phase_acc[c] = '0;
                key[c]       = '0;
                step[c]      = '0;
                xor_mask[c]  = '0;
                offset[c]    = '0;
            end
            active = '0;
            errors = 0;
        endfunction

        // Apply one accepted transfer; a tick queues its expected sample
        function void note_transfer(logic op, logic [7:0] addr, logic [7:0] data);
            int unsigned  c;
            logic [31:0]  sum;
            logic [7:0]   idx;
            logic [7:0]   v;
            tick_result_t res;
            if (op == wts4_pkg::OP_TICK)
            begin
                sum = 32'(wts4_pkg::MIX_BIAS);
                for (c = 0; c < wts4_pkg::CHANNELS; c++)
                begin
                    if (active[c])
                    begin
                        phase_acc[c] = phase_acc[c] + 16'(step[c]);
                        idx = (phase_acc[c][14:7] & 8'hFC) ^ xor_mask[c];
                        v = wave_mem[idx] + offset[c];
                        sum = sum + (v[7] ? 32'd63 : 32'(v[5:0]));
                    end
                end
                res.sample      = 8'(sum - 32'(wts4_pkg::MIX_CENTER));
                res.active_mask = active;
                expected_q.push_back(res);
            end
            else if (addr >= wts4_pkg::TABLE_BASE)
            begin
                wave_mem[addr] = data;
            end
            else
            begin
                c = {30'd0, addr[1:0]};
                if (c < wts4_pkg::CHANNELS)
                begin
                    case (addr[4:2])
                        wts4_pkg::RGN_KEY_LO:
                        begin
                            key[c] = {key[c][13:7], data[6:0]};
                            if (key[c] != 0)
                                active[c] = 1'b1;
                        end
                        wts4_pkg::RGN_KEY_HI:
                        begin
                            key[c]  = {data[6:0], key[c][6:0]};
                            step[c] = 13'((32'(key[c]) * 32'd44) / 32'd101);
                            if (key[c] != 0)
                            begin
                                phase_acc[c] = '0;
                                active[c]    = 1'b1;
                            end
                        end
                        wts4_pkg::RGN_XOR:     xor_mask[c] = data;
                        wts4_pkg::RGN_OFFSET:  offset[c] = data;
                        wts4_pkg::RGN_NOTEOFF:
                        begin
                            key[c]    = '0;
                            step[c]   = '0;
                            active[c] = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
        endfunction

        function void check_result(logic [15:0] tdata);
            tick_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: tdata=%h", tdata);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (tdata[7:0] !== exp_res.sample)
            begin
                $error("sample: expected %0d, actual %0d",
                       $signed(exp_res.sample), $signed(tdata[7:0]));
                errors++;
            end
            if (tdata[11:8] !== exp_res.active_mask)
            begin
                $error("active_mask: expected %h, actual %h", exp_res.active_mask, tdata[11:8]);
                errors++;
            end
            if (tdata[15:12] !== 4'h0)
            begin
                $error("tdata pad: expected 0, actual %h", tdata[15:12]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [7:0] reg_address, [15:8] write_data
    logic        s_axis_tuser;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] sample, [11:8] active_mask

    synth_scoreboard sb;

    // Idle rates in percent per item/cycle; zero during the closing stretch
    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;

    wavetable_synth_four_channel_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 2k items, each with
    // worst-case source gaps and sink stalls)
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Sample both handshakes at the falling edge: inputs only move at the rising
    // edge, so what is seen here is exactly what the next rising edge accepts.
    // Note the input first, then check the output against the oldest expectation.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_transfer(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Output side: hold tready low in random bursts, at the rate set by sink_stall_pct
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && $urandom_range(0, 99) < sink_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] reg_addr(logic [2:0] region, int unsigned chan);
        return {3'b000, region, 2'(chan)};
    endfunction

    // Present one transfer, optionally after a gap, and wait until it is taken.
    // Called at a rising edge; returns at the rising edge that accepts the transfer.
    task automatic push_item(logic op, logic [7:0] addr, logic [7:0] data);
        logic taken;
        if ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {data, addr};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
    endtask

    task automatic push_write(logic [7:0] addr, logic [7:0] data);
        push_item(wts4_pkg::OP_WRITE, addr, data);
    endtask

    // Tick with junk in the address and data fields, which the block must ignore
    task automatic push_tick();
        push_item(wts4_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    // Walk the corner cases: silent mix, key halves at their extremes, zero keys,
    // clamping offsets, XOR, table edges, note-off
    task automatic run_directed();
        push_item(wts4_pkg::OP_TICK, 8'h00, 8'h00);
        push_item(wts4_pkg::OP_TICK, 8'hFF, 8'hFF);
        push_write(reg_addr(wts4_pkg::RGN_KEY_LO, 0), 8'hFF);  // low half alone: ch0 active
        push_tick();
        push_write(reg_addr(wts4_pkg::RGN_KEY_HI, 0), 8'h7F);  // largest key, largest step
        push_write(reg_addr(wts4_pkg::RGN_KEY_HI, 1), 8'h00);  // zero key: stays idle
        push_write(reg_addr(wts4_pkg::RGN_KEY_HI, 1), 8'h80);  // bit 7 dropped, still zero
        push_write(reg_addr(wts4_pkg::RGN_KEY_HI, 2), 8'h01);
        push_write(reg_addr(wts4_pkg::RGN_XOR, 0), 8'hFF);
        push_write(reg_addr(wts4_pkg::RGN_OFFSET, 0), 8'h80);  // negative offset wraps
        push_write(reg_addr(wts4_pkg::RGN_OFFSET, 2), 8'h7F);
        push_write(reg_addr(wts4_pkg::RGN_OFFSET, 3), 8'hFF);
        push_write(reg_addr(wts4_pkg::RGN_KEY_LO, 3), 8'h01);
        push_write(reg_addr(wts4_pkg::RGN_KEY_HI, 3), 8'h40);
        push_write(wts4_pkg::TABLE_BASE, 8'hFF);               // lowest writable table byte
        push_write(8'hFF, 8'h00);                              // highest table byte
        push_tick();
        push_tick();
        push_tick();
        push_write(reg_addr(wts4_pkg::RGN_NOTEOFF, 0), 8'h00);
        push_write(reg_addr(wts4_pkg::RGN_NOTEOFF, 3), 8'hFF);
        push_tick();
        push_write(reg_addr(wts4_pkg::RGN_KEY_LO, 1), 8'h80);  // key still zero: no activation
        push_tick();
        push_write(reg_addr(wts4_pkg::RGN_KEY_HI, 0), 8'h00);  // zero high half keeps phase
        push_tick();
    endtask

    // Mostly ticks and channel setup with random content, plus table writes and
    // fully random writes anywhere in the address space
    task automatic run_random(int unsigned count);
        int unsigned pick;
        int unsigned ch;
        logic [7:0]  data;
        for (int unsigned n = 0; n < count; n++)
        begin
            // Re-draw idle rates every 100 items; close out with no idling at all
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: src_gap_pct = 0;
                    1: src_gap_pct = 10;
                    default: src_gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_stall_pct = 0;
                    1: sink_stall_pct = 10;
                    default: sink_stall_pct = 35;
                endcase
            end
            if (n + 200 >= count)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            pick = $urandom_range(0, 99);
            ch   = $urandom_range(0, 3);
            data = 8'($urandom);
            if (pick < 45)
                push_tick();
            else if (pick < 58)
            begin
                // Favor small keys now and then so phases sweep the table slowly
                if ($urandom_range(0, 3) == 0)
                    data = 8'($urandom_range(0, 3)) | (data & 8'h80);
                push_write(reg_addr(wts4_pkg::RGN_KEY_HI, ch), data);
            end
            else if (pick < 66)
                push_write(reg_addr(wts4_pkg::RGN_KEY_LO, ch), data);
            else if (pick < 73)
                push_write(reg_addr(wts4_pkg::RGN_XOR, ch), data);
            else if (pick < 80)
                push_write(reg_addr(wts4_pkg::RGN_OFFSET, ch), data);
            else if (pick < 84)
                push_write(reg_addr(wts4_pkg::RGN_NOTEOFF, ch), data);
            else if (pick < 94)
                push_write(8'($urandom_range(wts4_pkg::TABLE_BASE, 255)), data);
            else
                push_write(8'($urandom), data);
        end
    endtask

    initial
    begin
        sb             = new();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tuser   <= wts4_pkg::OP_WRITE;
        s_axis_tdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gap_pct    = 20;
        sink_stall_pct = 20;
        run_directed();
        run_random(1850);
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected sample, then keep the clock running to catch strays
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wts4_pkg.sv
hw/rtl/wts4_ram.sv
hw/rtl/wavetable_synth_four_channel_unit.sv
hw/rtl/wts4_chk.sv
bench/wavetable_synth_four_channel_unit_tb.sv
